// ----- rtl/core/gha_pkg.sv -----
// Shared types and constants for the generational handle allocator.
// No dependencies; used by gha_free_fifo and generational_handle_allocator.
package gha_pkg;

	localparam int SLOTS = 256;
	localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CNT_W = IDX_W + 1;

	localparam logic [1:0] ACT_REGISTER = 2'd0;
	localparam logic [1:0] ACT_FREE     = 2'd1;
	localparam logic [1:0] ACT_VALIDATE = 2'd2;
	localparam logic [1:0] ACT_LOOKUP   = 2'd3;

	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_FULL  = 2'd1;
	localparam logic [1:0] STAT_RANGE = 2'd2;
	localparam logic [1:0] STAT_FREED = 2'd3;

	// control into the free-slot queue
	typedef struct packed {
		logic push;
		logic pop;
	} fq_ctl_t;

	// status out of the free-slot queue
	typedef struct packed {
		logic [CNT_W-1:0] count;
	} fq_stat_t;

	function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] p);
		return (p == IDX_W'(SLOTS - 1)) ? '0 : p + 1'b1;
	endfunction

endpackage

// ----- rtl/core/generational_handle_allocator.sv -----
// Generational handle allocator: slot table in one synchronous memory,
// freed slots in a FIFO (gha_free_fifo). Depends on gha_pkg.
// Register-append, full and out-of-range register their result on the accept;
// free, validate and lookup first read the slot (ST_SLOT); register-reuse
// first pops the free queue (ST_QRD), then reads the slot (ST_SLOT). busy is
// high in those states; the result strobe is one cycle and cannot be stalled.
// arst_n clears control state, slot count and queue pointers; memories keep junk.
module generational_handle_allocator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  action,
	input  logic [31:0] handle_index,
	input  logic [31:0] handle_generation,
	input  logic [3:0]  resource_type,
	input  logic [31:0] resource_ref,
	output logic        done,
	output logic [1:0]  status,
	output logic [7:0]  out_index,
	output logic [31:0] out_generation,
	output logic        handle_ok,
	output logic [31:0] entry_ref,
	output logic [3:0]  entry_type,
	output logic        entry_live
);
	import gha_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_QRD  = 3'b010,
		ST_SLOT = 3'b100
	} state_t;

	typedef struct packed {
		logic        live;
		logic [3:0]  rtype;
		logic [31:0] rref;
		logic [31:0] gen;
	} slot_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [7:0]  index;
		logic [31:0] gen;
		logic        ok;
		logic [31:0] rref;
		logic [3:0]  rtype;
		logic        live;
	} res_t;

	state_t           state_q, state_d;
	logic [1:0]       action_q;
	logic [31:0]      gen_q;
	logic [3:0]       type_q;
	logic [31:0]      ref_q;
	logic [IDX_W-1:0] addr_q, addr_d;
	logic [CNT_W-1:0] used_q;

	slot_t            mem [SLOTS];
	slot_t            rd_q;
	logic [IDX_W-1:0] rd_addr;
	logic             we;
	logic [IDX_W-1:0] waddr;
	slot_t            wdata;

	fq_ctl_t          fq_ctl;
	fq_stat_t         fq_st;
	logic [IDX_W-1:0] fq_idx;

	res_t             res, res_q;
	logic             res_vld, done_q;
	logic             accept, in_range, used_inc;

	gha_free_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (fq_ctl),
		.push_idx (addr_q),
		.pop_idx  (fq_idx),
		.st       (fq_st)
	);

	assign busy     = (state_q != ST_IDLE);
	assign accept   = start && !busy;
	assign in_range = handle_index < 32'(used_q);

	always_comb begin
		state_d  = state_q;
		addr_d   = addr_q;
		res      = '0;
		res_vld  = 1'b0;
		we       = 1'b0;
		waddr    = addr_q;
		wdata    = rd_q;
		fq_ctl   = '0;
		used_inc = 1'b0;
		rd_addr  = handle_index[IDX_W-1:0];

		unique case (state_q)
			ST_IDLE: begin
				addr_d = handle_index[IDX_W-1:0];
				if (accept) begin
					if (action == ACT_REGISTER) begin
						if (fq_st.count != '0) begin
							fq_ctl.pop = 1'b1;
							state_d    = ST_QRD;
						end else if (used_q != CNT_W'(SLOTS)) begin
							// append a fresh slot at generation 1
							we         = 1'b1;
							waddr      = used_q[IDX_W-1:0];
							wdata      = '{live: 1'b1, rtype: resource_type,
							               rref: resource_ref, gen: 32'd1};
							used_inc   = 1'b1;
							res_vld    = 1'b1;
							res.status = STAT_OK;
							res.index  = 8'(used_q[IDX_W-1:0]);
							res.gen    = 32'd1;
						end else begin
							res_vld    = 1'b1;
							res.status = STAT_FULL;
						end
					end else if (!in_range) begin
						res_vld    = 1'b1;
						res.status = STAT_RANGE;
					end else begin
						state_d = ST_SLOT;
					end
				end
			end
			ST_QRD: begin
				rd_addr = fq_idx;
				addr_d  = fq_idx;
				state_d = ST_SLOT;
			end
			ST_SLOT: begin
				res_vld    = 1'b1;
				res.status = STAT_OK;
				state_d    = ST_IDLE;
				unique case (action_q)
					ACT_REGISTER: begin
						we        = 1'b1;
						wdata     = '{live: 1'b1, rtype: type_q, rref: ref_q,
						              gen: rd_q.gen + 32'd1};
						res.index = 8'(addr_q);
						res.gen   = rd_q.gen + 32'd1;
					end
					ACT_FREE: begin
						if (!rd_q.live) begin
							res.status = STAT_FREED;
						end else begin
							we          = 1'b1;
							wdata.live  = 1'b0;
							wdata.rref  = '0;
							fq_ctl.push = 1'b1;
						end
					end
					ACT_VALIDATE: begin
						res.ok = rd_q.live && (rd_q.gen == gen_q) &&
						         (rd_q.rref != '0) && (rd_q.rtype == type_q);
					end
					ACT_LOOKUP: begin
						res.index = 8'(addr_q);
						res.gen   = rd_q.gen;
						res.rref  = rd_q.rref;
						res.rtype = rd_q.rtype;
						res.live  = rd_q.live;
					end
					default: ;
				endcase
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// slot table: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		addr_q <= addr_d;
		if (res_vld) begin
			res_q <= res;
		end
		if (accept) begin
			action_q <= action;
			gen_q    <= handle_generation;
			type_q   <= resource_type;
			ref_q    <= resource_ref;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			used_q  <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= res_vld;
			if (used_inc) begin
				used_q <= used_q + 1'b1;
			end
		end
	end

	assign done           = done_q;
	assign status         = res_q.status;
	assign out_index      = res_q.index;
	assign out_generation = res_q.gen;
	assign handle_ok      = res_q.ok;
	assign entry_ref      = res_q.rref;
	assign entry_type     = res_q.rtype;
	assign entry_live     = res_q.live;

	a_free_le_used: assert property (@(posedge clk) disable iff (!arst_n)
		fq_st.count <= used_q)
		else $error("more queued free slots than allocated slots");

	a_full_means_full: assert property (@(posedge clk) disable iff (!arst_n)
		done && status == STAT_FULL |-> used_q == CNT_W'(SLOTS) && fq_st.count == '0)
		else $error("table full reported with room left");

	a_done_source: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept) || $past(state_q == ST_SLOT))
		else $error("result strobe without a transfer in flight");

	a_qrd_to_slot: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_QRD |=> state_q == ST_SLOT && action_q == ACT_REGISTER)
		else $error("queue read not followed by slot read");

endmodule

// ----- rtl/core/gha_free_fifo.sv -----
// FIFO of freed slot indices: one synchronous memory plus head/tail/count.
// Depends on gha_pkg. Pop data is registered: it appears in the cycle after the pop request.
module gha_free_fifo (
	input  logic                     clk,
	input  logic                     arst_n,
	input  gha_pkg::fq_ctl_t         ctl,
	input  logic [gha_pkg::IDX_W-1:0] push_idx,
	output logic [gha_pkg::IDX_W-1:0] pop_idx,
	output gha_pkg::fq_stat_t        st
);
	import gha_pkg::*;

	logic [IDX_W-1:0] mem [SLOTS];
	logic [IDX_W-1:0] head_q;
	logic [IDX_W-1:0] tail_q;
	logic [CNT_W-1:0] count_q;

	always_ff @(posedge clk) begin
		if (ctl.push) begin
			mem[tail_q] <= push_idx;
		end
		pop_idx <= mem[head_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			if (ctl.push) begin
				tail_q <= wrap_inc(tail_q);
			end
			if (ctl.pop) begin
				head_q <= wrap_inc(head_q);
			end
			unique case ({ctl.push, ctl.pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	assign st.count = count_q;

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.pop |-> count_q != '0)
		else $error("pop from empty free queue");

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.push |-> count_q != CNT_W'(SLOTS))
		else $error("push into full free queue");

	a_pop_moves_head: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.pop && !ctl.push |=> count_q == $past(count_q) - 1'b1)
		else $error("free count did not drop on pop");

endmodule
